// ===== rtl/core/signed_fixnum_alu_assert.svh =====
// Assertion macros used by the ALU top level.
`ifndef SIGNED_FIXNUM_ALU_ASSERT_SVH
`define SIGNED_FIXNUM_ALU_ASSERT_SVH

// Property checked at every rising clock edge outside reset.
`define SFA_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Same-cycle implication outside reset.
`define SFA_ASSERT_IMPL(lbl, ante, cons, msg) \
  `SFA_ASSERT_RST(lbl, (ante) |-> (cons), msg)

`endif

// ===== rtl/core/sfa_pkg.sv =====
// Package: operation codes and error codes of the signed integer ALU.
`timescale 1ns / 1ps
`default_nettype none

package sfa_pkg;

  localparam int FUNC_BITS = 4;
  localparam int ERR_BITS  = 2;

  typedef enum logic [FUNC_BITS-1:0] {
    FN_ADD = 4'd0,
    FN_SUB = 4'd1,
    FN_MUL = 4'd2,
    FN_DIV = 4'd3,
    FN_MOD = 4'd4,
    FN_REM = 4'd5,
    FN_XOR = 4'd6,
    FN_EQ  = 4'd7,
    FN_NE  = 4'd8,
    FN_LT  = 4'd9,
    FN_LE  = 4'd10,
    FN_GT  = 4'd11,
    FN_GE  = 4'd12
  } fn_t;

  typedef enum logic [ERR_BITS-1:0] {
    ERR_NONE  = 2'd0,
    ERR_DIV0  = 2'd1,
    ERR_RANGE = 2'd2
  } err_t;

endpackage

`default_nettype wire

// ===== rtl/core/sfa_if.sv =====
// Interfaces: request and result channels of the ALU.
`timescale 1ns / 1ps
`default_nettype none

interface sfa_in_if import sfa_pkg::*; #(parameter int W = 60) ();
  logic                 valid;
  logic                 ready;
  logic [FUNC_BITS-1:0] func;
  logic signed [W-1:0]  operand_a;
  logic signed [W-1:0]  operand_b;

  modport source (output valid, func, operand_a, operand_b, input ready);
  modport sink   (input valid, func, operand_a, operand_b, output ready);
endinterface

interface sfa_out_if import sfa_pkg::*; #(parameter int W = 60) ();
  logic                 valid;
  logic                 ready;
  logic signed [W-1:0]  result_value;
  logic [ERR_BITS-1:0]  error_code;

  modport source (output valid, result_value, error_code, input ready);
  modport sink   (input valid, result_value, error_code, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/sfa_div.sv =====
// Pipelined unsigned restoring divider, one quotient bit per stage.
`timescale 1ns / 1ps
`default_nettype none

module sfa_div #(
  parameter int W = 60
) (
  input  logic         clk,
  input  logic         en,
  input  logic [W-1:0] dividend,
  input  logic [W-1:0] divisor,
  output logic [W-1:0] quot,
  output logic [W-1:0] rem
);

  logic [W-1:0] r [1:W];
  logic [W-1:0] n [1:W];
  logic [W-1:0] q [1:W];
  logic [W-1:0] d [1:W];

  logic [W-1:0] r_in [1:W];
  logic [W-1:0] n_in [1:W];
  logic [W-1:0] q_in [1:W];
  logic [W-1:0] d_in [1:W];

  always_comb begin
    r_in[1] = '0;
    n_in[1] = dividend;
    q_in[1] = '0;
    d_in[1] = divisor;
    for (int k = 2; k <= W; k++) begin
      r_in[k] = r[k-1];
      n_in[k] = n[k-1];
      q_in[k] = q[k-1];
      d_in[k] = d[k-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 1; k <= W; k++) begin
        logic [W:0] t;
        logic [W:0] dif;
        t   = {r_in[k], n_in[k][W-1]};
        dif = t - {1'b0, d_in[k]};
        // borrow clear means the shifted remainder covers the divisor
        if (!dif[W]) begin
          r[k] <= dif[W-1:0];
          q[k] <= {q_in[k][W-2:0], 1'b1};
        end else begin
          r[k] <= t[W-1:0];
          q[k] <= {q_in[k][W-2:0], 1'b0};
        end
        n[k] <= {n_in[k][W-2:0], 1'b0};
        d[k] <= d_in[k];
      end
    end
  end

  assign quot = q[W];
  assign rem  = r[W];

endmodule

`default_nettype wire

// ===== rtl/core/sfa_mul.sv =====
// Four-stage signed multiplier from half-width partial products, with range check.
`timescale 1ns / 1ps
`default_nettype none

module sfa_mul #(
  parameter int W = 60
) (
  input  logic                clk,
  input  logic                en,
  input  logic signed [W-1:0] a,
  input  logic signed [W-1:0] b,
  output logic [W-1:0]        prod,
  output logic                ovf
);

  localparam int H = (W + 1) / 2;

  logic [2*H-1:0] am, bm;
  logic [2*H-1:0] pp_ll, pp_lh, pp_hl, pp_hh;
  logic           neg1, neg2, neg3;
  logic [2*H:0]   mid;
  logic [2*H-1:0] ll2, hh2;
  logic [4*H-1:0] p;
  logic [4*H-1:0] lim;

  always_comb begin
    am = {{(2*H-W){1'b0}}, (a[W-1] ? (~a + 1'b1) : a)};
    bm = {{(2*H-W){1'b0}}, (b[W-1] ? (~b + 1'b1) : b)};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pp_ll <= am[H-1:0]   * bm[H-1:0];
      pp_lh <= am[H-1:0]   * bm[2*H-1:H];
      pp_hl <= am[2*H-1:H] * bm[H-1:0];
      pp_hh <= am[2*H-1:H] * bm[2*H-1:H];
      neg1  <= a[W-1] ^ b[W-1];

      mid   <= {1'b0, pp_lh} + {1'b0, pp_hl};
      ll2   <= pp_ll;
      hh2   <= pp_hh;
      neg2  <= neg1;

      p     <= {hh2, ll2} + {{(H-1){1'b0}}, mid, {H{1'b0}}};
      neg3  <= neg2;

      ovf   <= p > lim;
      prod  <= neg3 ? (~p[W-1:0] + 1'b1) : p[W-1:0];
    end
  end

  // magnitude may reach 2**(W-1) only when the product is negative
  always_comb begin
    lim = ({{(4*H-1){1'b0}}, 1'b1} << (W - 1)) - {{(4*H-1){1'b0}}, !neg3};
  end

endmodule

`default_nettype wire

// ===== rtl/core/signed_fixnum_alu.sv =====
// Top level: pipelined signed ALU: add, sub, mul, div, mod, rem, xor and compares.
//
//  channel | dir | handshake     | payload
//  req     | in  | valid / ready | func, operand_a, operand_b
//  rsp     | out | valid / ready | result_value, error_code
//
// One request per cycle while the pipe does not hold; its depth is set by the divider,
// which resolves one quotient bit per stage. The multiplier takes four stages
// and rides alongside. Synchronous reset clears the valid bits only.
// When the result register is full and not taken the whole pipe holds.
`timescale 1ns / 1ps
`default_nettype none
`include "signed_fixnum_alu_assert.svh"

module signed_fixnum_alu import sfa_pkg::*; #(
  parameter int VALUE_BITS = 60
) (
  input  logic      clk,
  input  logic      rst,
  sfa_in_if.sink    req,
  sfa_out_if.source rsp
);

  localparam int W = VALUE_BITS;
  localparam int L = W + 2;

  logic [L-1:0] vld;
  logic         en;

  logic [FUNC_BITS-1:0] f0;
  logic signed [W-1:0]  a0, b0;

  logic [W:0]           sum_add, sum_sub;
  logic [W-1:0]         fast_res;
  logic [ERR_BITS-1:0]  fast_err;

  logic [FUNC_BITS-1:0] sd_func [1:W];
  logic [W-1:0]         sd_res  [1:W];
  logic [ERR_BITS-1:0]  sd_err  [1:W];
  logic                 sd_aneg [1:W];
  logic signed [W-1:0]  sd_b    [1:W];

  logic [W-1:0] mul_prod;
  logic         mul_ovf;
  logic [W-1:0] mr_d [5:W];
  logic         mo_d [5:W];

  logic [W-1:0] quot, rem;
  logic [W-1:0] am0, bm0;

  logic [W-1:0]         res_next;
  logic [ERR_BITS-1:0]  err_next;
  logic [W-1:0]         res_q;
  logic [ERR_BITS-1:0]  err_q;
  logic [FUNC_BITS-1:0] func_q;

  assign en        = !vld[L-1] || rsp.ready;
  // no request is taken while reset clears the valid bits
  assign req.ready = en && !rst;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[L-2:0], req.valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      f0 <= req.func;
      a0 <= req.operand_a;
      b0 <= req.operand_b;
    end
  end

  // operations computed combinationally from the input register
  always_comb begin
    sum_add  = {a0[W-1], a0} + {b0[W-1], b0};
    sum_sub  = {a0[W-1], a0} - {b0[W-1], b0};
    fast_res = '0;
    fast_err = ERR_NONE;
    case (f0)
      FN_ADD: begin
        fast_res = sum_add[W-1:0];
        if (sum_add[W] != sum_add[W-1]) fast_err = ERR_RANGE;
      end
      FN_SUB: begin
        fast_res = sum_sub[W-1:0];
        if (sum_sub[W] != sum_sub[W-1]) fast_err = ERR_RANGE;
      end
      FN_XOR: fast_res = a0 ^ b0;
      FN_EQ:  fast_res = {{(W-1){1'b0}}, a0 == b0};
      FN_NE:  fast_res = {{(W-1){1'b0}}, a0 != b0};
      FN_LT:  fast_res = {{(W-1){1'b0}}, a0 <  b0};
      FN_LE:  fast_res = {{(W-1){1'b0}}, a0 <= b0};
      FN_GT:  fast_res = {{(W-1){1'b0}}, a0 >  b0};
      FN_GE:  fast_res = {{(W-1){1'b0}}, a0 >= b0};
      default: fast_res = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sd_func[1] <= f0;
      sd_res[1]  <= fast_res;
      sd_err[1]  <= fast_err;
      sd_aneg[1] <= a0[W-1];
      sd_b[1]    <= b0;
      for (int k = 2; k <= W; k++) begin
        sd_func[k] <= sd_func[k-1];
        sd_res[k]  <= sd_res[k-1];
        sd_err[k]  <= sd_err[k-1];
        sd_aneg[k] <= sd_aneg[k-1];
        sd_b[k]    <= sd_b[k-1];
      end
    end
  end

  sfa_mul #(.W(W)) u_mul (
    .clk  (clk),
    .en   (en),
    .a    (a0),
    .b    (b0),
    .prod (mul_prod),
    .ovf  (mul_ovf)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      mr_d[5] <= mul_prod;
      mo_d[5] <= mul_ovf;
      for (int k = 6; k <= W; k++) begin
        mr_d[k] <= mr_d[k-1];
        mo_d[k] <= mo_d[k-1];
      end
    end
  end

  assign am0 = a0[W-1] ? (~a0 + 1'b1) : a0;
  assign bm0 = b0[W-1] ? (~b0 + 1'b1) : b0;

  sfa_div #(.W(W)) u_div (
    .clk      (clk),
    .en       (en),
    .dividend (am0),
    .divisor  (bm0),
    .quot     (quot),
    .rem      (rem)
  );

  // sign fix-up of quotient and remainder, then final select and divide-by-zero override
  always_comb begin
    logic         qneg;
    logic [W-1:0] qv, rv;
    logic [W:0]   rs;
    logic         bzero;
    qneg  = sd_aneg[W] ^ sd_b[W][W-1];
    qv    = qneg ? (~quot + 1'b1) : quot;
    rv    = sd_aneg[W] ? (~rem + 1'b1) : rem;
    rs    = {rv[W-1], rv} + {sd_b[W][W-1], sd_b[W]};
    bzero = sd_b[W] == '0;
    res_next = sd_res[W];
    err_next = sd_err[W];
    case (sd_func[W])
      FN_MUL: begin
        res_next = mr_d[W];
        err_next = mo_d[W] ? ERR_RANGE : ERR_NONE;
      end
      FN_DIV: begin
        res_next = qv;
        // only the most negative value over minus one leaves the range
        err_next = (!qneg && quot[W-1]) ? ERR_RANGE : ERR_NONE;
      end
      FN_MOD: begin
        res_next = rv;
        err_next = ERR_NONE;
      end
      FN_REM: begin
        if (rv[W-1]) begin
          res_next = rs[W-1:0];
          err_next = (rs[W] != rs[W-1]) ? ERR_RANGE : ERR_NONE;
        end else begin
          res_next = rv;
          err_next = ERR_NONE;
        end
      end
      default: begin
        res_next = sd_res[W];
        err_next = sd_err[W];
      end
    endcase
    if ((sd_func[W] == FN_DIV || sd_func[W] == FN_MOD || sd_func[W] == FN_REM) && bzero) begin
      res_next = '0;
      err_next = ERR_DIV0;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res_q  <= res_next;
      err_q  <= err_next;
      func_q <= sd_func[W];
    end
  end

  assign rsp.valid        = vld[L-1];
  assign rsp.result_value = res_q;
  assign rsp.error_code   = err_q;

  `SFA_ASSERT_IMPL(a_div0_only_div, rsp.valid && rsp.error_code == ERR_DIV0,
    func_q == FN_DIV || func_q == FN_MOD || func_q == FN_REM, "div-by-zero on non-divide")

  `SFA_ASSERT_IMPL(a_cmp_is_bool,
    rsp.valid && (func_q == FN_EQ || func_q == FN_NE || func_q == FN_LT ||
    func_q == FN_LE || func_q == FN_GT || func_q == FN_GE),
    rsp.result_value[W-1:1] == '0 && rsp.error_code == ERR_NONE, "compare not 0/1")

  `SFA_ASSERT_RST(a_stall_freeze, (rsp.valid && !rsp.ready) |=> vld == $past(vld),
    "pipe moved during stall")

endmodule

`default_nettype wire

// ===== verif/sfa_checker.sv =====
// Checker: watches the ALU channels, predicts each result and compares.
`timescale 1ns / 1ps

module sfa_checker import sfa_pkg::*; #(
  parameter int W = 60
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [3:0]  in_func,
  input  logic [W-1:0] in_a,
  input  logic [W-1:0] in_b,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [W-1:0] out_value,
  input  logic [1:0]  out_err,
  output int          fail_count,
  output int          pending
);

  typedef struct packed {
    logic [W-1:0] value;
    logic [1:0]   err;
  } alu_result_t;

  alu_result_t result_q[$];

  function automatic alu_result_t alu_predict(logic [3:0] fn, logic [W-1:0] ra,
                                              logic [W-1:0] rb);
    logic signed [W+1:0]   x, y, z;
    logic signed [2*W+1:0] p;
    logic signed [W+1:0]   vmax, vmin;
    alu_result_t r;
    x = {{2{ra[W-1]}}, ra};
    y = {{2{rb[W-1]}}, rb};
    vmax = (W+2)'((64'd1 << (W-1)) - 1);
    vmin = -vmax - 1;
    r.value = '0;
    r.err = ERR_NONE;
    z = '0;
    case (fn)
      FN_ADD, FN_SUB: begin
        z = (fn == FN_ADD) ? x + y : x - y;
        r.value = z[W-1:0];
        if (z > vmax || z < vmin) r.err = ERR_RANGE;
      end
      FN_MUL: begin
        p = (2*W+2)'($signed({{(W+2){x[W+1]}}, x}) * $signed({{(W+2){y[W+1]}}, y}));
        r.value = p[W-1:0];
        if (p > $signed({{W{1'b0}}, vmax}) || p < $signed({{W{1'b1}}, vmin}))
          r.err = ERR_RANGE;
      end
      FN_DIV, FN_MOD, FN_REM: begin
        if (y == 0) begin
          r.err = ERR_DIV0;
        end else begin
          if (fn == FN_DIV) z = x / y;
          else begin
            z = x % y;
            if (fn == FN_REM && z < 0) z = z + y;
          end
          r.value = z[W-1:0];
          if (z > vmax || z < vmin) r.err = ERR_RANGE;
        end
      end
      FN_XOR: r.value = ra ^ rb;
      FN_EQ:  r.value = W'(x == y);
      FN_NE:  r.value = W'(x != y);
      FN_LT:  r.value = W'(x < y);
      FN_LE:  r.value = W'(x <= y);
      FN_GT:  r.value = W'(x > y);
      FN_GE:  r.value = W'(x >= y);
      default: ;
    endcase
    return r;
  endfunction

  always @(posedge clk) begin
    alu_result_t e;
    if (!rst) begin
      if (in_valid && in_ready) result_q.push_back(alu_predict(in_func, in_a, in_b));
      if (out_valid && out_ready) begin
        if (result_q.size() == 0) begin
          fail_count <= fail_count + 1;
          if (fail_count < 10) $display("unexpected result %h err %0d", out_value, out_err);
        end else begin
          e = result_q.pop_front();
          if (e.value !== out_value || e.err !== out_err) begin
            fail_count <= fail_count + 1;
            if (fail_count < 10)
              $display("mismatch: expected %h err %0d, got %h err %0d",
                       e.value, e.err, out_value, out_err);
          end
        end
      end
    end
    pending = result_q.size();
  end

endmodule

// ===== verif/tb_signed_fixnum_alu.sv =====
// Testbench top: drives requests and result stalls, gives the verdict.
`timescale 1ns / 1ps

module tb_signed_fixnum_alu;
  import sfa_pkg::*;

  localparam int W = 60;
  localparam int LAT = W + 2;

  logic clk;
  logic rst;
  int   send_idle;
  int   recv_stall;
  bit   hold_off;
  int   fails;
  int   pending;

  sfa_in_if  #(.W(W)) req ();
  sfa_out_if #(.W(W)) rsp ();

  signed_fixnum_alu #(.VALUE_BITS(W)) u_top (
    .clk(clk), .rst(rst), .req(req.sink), .rsp(rsp.source)
  );

  sfa_checker #(.W(W)) u_chk (
    .clk(clk), .rst(rst),
    .in_valid(req.valid), .in_ready(req.ready), .in_func(req.func),
    .in_a(req.operand_a), .in_b(req.operand_b),
    .out_valid(rsp.valid), .out_ready(rsp.ready),
    .out_value(rsp.result_value), .out_err(rsp.error_code),
    .fail_count(fails), .pending(pending)
  );

  initial begin
    clk = 0;
    forever #2 clk = ~clk;
  end

  initial begin
    #2000000;
    $display("signed_fixnum_alu regression: fail");
    $finish;
  end

  // receiver: random stalls, plus a long hold-off on request
  initial begin
    rsp.ready = 0;
    forever begin
      @(negedge clk);
      if (hold_off) rsp.ready <= 0;
      else rsp.ready <= ($urandom_range(99) >= recv_stall);
    end
  end

  function automatic logic [W-1:0] pick_operand();
    case ($urandom_range(9))
      0: return {1'b0, {(W-1){1'b1}}};
      1: return {1'b1, {(W-1){1'b0}}};
      2: return '0;
      3: return W'(1);
      4: return '1;
      5: return W'($urandom_range(20)) - W'(10);
      6: return W'(signed'($urandom_range(65535)) - 32768);
      7: return W'({$urandom, $urandom} >> $urandom_range(W-1));
      default: return W'({$urandom, $urandom});
    endcase
  endfunction

  // driven at the falling edge, so the drop and re-raise of valid between
  // back-to-back requests never reaches a rising edge
  task automatic send_op(logic [3:0] fn, logic [W-1:0] a, logic [W-1:0] b);
    while ($urandom_range(99) < send_idle) @(negedge clk);
    req.valid = 1;
    req.func = fn;
    req.operand_a = a;
    req.operand_b = b;
    @(posedge clk);
    while (!req.ready) @(posedge clk);
    @(negedge clk);
    req.valid = 0;
  endtask

  task automatic run_random(int n);
    logic [3:0] fn;
    for (int i = 0; i < n; i++) begin
      fn = ($urandom_range(15) == 0) ? 4'($urandom_range(15, 13)) : 4'($urandom_range(12));
      send_op(fn, pick_operand(), pick_operand());
    end
  endtask

  task automatic drain();
    while (pending != 0) @(negedge clk);
  endtask

  logic [W-1:0] vmax, vmin;

  initial begin
    vmax = {1'b0, {(W-1){1'b1}}};
    vmin = {1'b1, {(W-1){1'b0}}};
    send_idle = 0;
    recv_stall = 0;
    hold_off = 0;
    rst = 1;
    req.valid = 0;
    req.func = '0;
    req.operand_a = '0;
    req.operand_b = '0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 0;

    // directed corners
    send_op(FN_ADD, vmax, W'(1));
    send_op(FN_ADD, vmin, vmin);
    send_op(FN_SUB, vmin, W'(1));
    send_op(FN_SUB, '1, vmax);
    send_op(FN_MUL, vmax, vmax);
    send_op(FN_MUL, vmin, '1);
    send_op(FN_MUL, {2'b11, {(W-2){1'b0}}}, W'(2));
    send_op(FN_DIV, vmin, '1);
    send_op(FN_DIV, W'(7), '0);
    send_op(FN_DIV, -W'(7), W'(2));
    send_op(FN_MOD, -W'(7), W'(2));
    send_op(FN_MOD, W'(7), '0);
    send_op(FN_REM, -W'(7), W'(2));
    send_op(FN_REM, -W'(7), -W'(2));
    send_op(FN_REM, vmin + W'(1), vmin);
    send_op(FN_REM, W'(3), '0);
    send_op(FN_XOR, vmax, vmin);
    send_op(FN_EQ, vmin, vmin);
    send_op(FN_NE, vmin, vmax);
    send_op(FN_LT, vmin, vmax);
    send_op(FN_LE, vmax, vmax);
    send_op(FN_GT, vmax, vmin);
    send_op(FN_GE, '1, '0);
    send_op(4'd13, vmax, vmax);
    send_op(4'd15, '1, '1);

    run_random(400);
    // sender pause until everything is back
    drain();
    send_idle = 76;
    run_random(300);
    send_idle = 0;
    recv_stall = 76;
    run_random(300);
    send_idle = 30;
    recv_stall = 30;
    run_random(250);
    // long receiver hold-off while requests keep coming
    send_idle = 0;
    recv_stall = 0;
    hold_off = 1;
    fork
      begin
        repeat (3 * LAT) @(negedge clk);
        hold_off = 0;
      end
      run_random(300);
    join

    drain();
    repeat (2 * LAT) @(negedge clk);
    if (fails == 0) $display("signed_fixnum_alu regression: pass");
    else $display("signed_fixnum_alu regression: fail");
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+rtl/core
rtl/core/sfa_pkg.sv
rtl/core/sfa_if.sv
rtl/core/sfa_div.sv
rtl/core/sfa_mul.sv
rtl/core/signed_fixnum_alu.sv
verif/sfa_checker.sv
verif/tb_signed_fixnum_alu.sv
